// ----- rtl/csed_pkg.sv -----
package csed_pkg;

  // scan modes of the escape decoder
  typedef enum logic [3:0] {
    MODE_PLAIN = 4'd0,
    MODE_ESC   = 4'd1,
    MODE_OCT   = 4'd2,
    MODE_DEC   = 4'd3,
    MODE_HEX   = 4'd4,
    MODE_ZX    = 4'd5
  } mode_e;

  // character codes
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_BELL      = 8'h07;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;
  localparam logic [7:0] CH_UPPER_X   = 8'h58;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_ONE       = 8'h31;
  localparam logic [7:0] CH_SEVEN     = 8'h37;
  localparam logic [7:0] CH_NINE      = 8'h39;

  // most results one character can release
  localparam int unsigned MaxRes = 3;

  // decoder state carried from one character to the next
  typedef struct packed {
    mode_e       mode;
    logic [9:0]  num;
    logic [1:0]  digits;
    logic [7:0]  held_byte;
    logic        held_valid;
  } st_t;

  // one result entry
  typedef struct packed {
    logic [7:0] data;
    logic       end_mark;
    logic       no_data;
  } res_t;

endpackage

// ----- rtl/csed_decode.sv -----
module csed_decode import csed_pkg::*; (
  input  st_t        st_i,
  input  logic [7:0] char_i,
  input  logic       final_i,
  output st_t        st_o,
  output res_t       res_o [MaxRes],
  output logic [1:0] res_cnt_o
);

  // hex digit value with a valid flag on top
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, c[3:0] + 4'd9};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  logic [4:0] hx;
  logic [7:0] dec_v [MaxRes];
  logic [1:0] dec_n;
  logic       do_plain;
  mode_e      mode;
  logic [9:0] num;
  logic [9:0] num_nx;
  logic [1:0] dig;
  logic [1:0] dig_nx;
  logic [7:0] lst [4];
  logic [2:0] n;
  logic [1:0] m;
  logic [1:0] last;

  always_comb begin
    hx       = hex_val(char_i);
    dec_n    = 2'd0;
    do_plain = 1'b0;
    mode     = st_i.mode;
    num      = st_i.num;
    dig      = st_i.digits;
    num_nx   = 10'd0;
    dig_nx   = dig + 2'd1;
    for (int i = 0; i < MaxRes; i++) dec_v[i] = 8'd0;

    case (st_i.mode)
      MODE_ESC: begin
        mode = MODE_PLAIN;
        num  = 10'd0;
        dig  = 2'd0;
        if (char_i == CH_LOWER_T) begin
          dec_v[dec_n] = CH_TAB; dec_n = dec_n + 2'd1;
        end else if (char_i == CH_LOWER_R) begin
          dec_v[dec_n] = CH_CR; dec_n = dec_n + 2'd1;
        end else if (char_i == CH_LOWER_N) begin
          dec_v[dec_n] = CH_LF; dec_n = dec_n + 2'd1;
        end else if (char_i == CH_LOWER_A) begin
          dec_v[dec_n] = CH_BELL; dec_n = dec_n + 2'd1;
        end else if (char_i == CH_ZERO) begin
          mode = MODE_OCT;
        end else if (char_i >= CH_ONE && char_i <= CH_NINE) begin
          mode = MODE_DEC;
          num  = {6'd0, char_i[3:0]};
          dig  = 2'd1;
        end else if (char_i == CH_LOWER_X) begin
          mode = MODE_HEX;
        end else begin
          dec_v[dec_n] = char_i; dec_n = dec_n + 2'd1;
        end
      end
      MODE_OCT: begin
        if (char_i >= CH_ZERO && char_i <= CH_SEVEN) begin
          num_nx = {st_i.num[6:0], char_i[2:0]};
          if (dig_nx == 2'd3) begin
            dec_v[dec_n] = num_nx[7:0]; dec_n = dec_n + 2'd1;
            mode = MODE_PLAIN; num = 10'd0; dig = 2'd0;
          end else begin
            num = num_nx; dig = dig_nx;
          end
        end else if (st_i.digits == 2'd0 &&
                     (char_i == CH_LOWER_X || char_i == CH_UPPER_X)) begin
          mode = MODE_ZX;
          num  = {2'd0, char_i};
        end else begin
          dec_v[dec_n] = st_i.num[7:0]; dec_n = dec_n + 2'd1;
          num = 10'd0; dig = 2'd0; do_plain = 1'b1;
        end
      end
      MODE_DEC: begin
        if (char_i >= CH_ZERO && char_i <= CH_NINE) begin
          num_nx = {st_i.num[8:0], 1'b0} + {st_i.num[6:0], 3'b000}
                 + {6'd0, char_i[3:0]};
          if (dig_nx == 2'd3) begin
            dec_v[dec_n] = num_nx[7:0]; dec_n = dec_n + 2'd1;
            mode = MODE_PLAIN; num = 10'd0; dig = 2'd0;
          end else begin
            num = num_nx; dig = dig_nx;
          end
        end else begin
          dec_v[dec_n] = st_i.num[7:0]; dec_n = dec_n + 2'd1;
          num = 10'd0; dig = 2'd0; do_plain = 1'b1;
        end
      end
      MODE_HEX: begin
        if (hx[4]) begin
          num_nx = {st_i.num[5:0], hx[3:0]};
          if (dig_nx >= 2'd2) begin
            dec_v[dec_n] = num_nx[7:0]; dec_n = dec_n + 2'd1;
            mode = MODE_PLAIN; num = 10'd0; dig = 2'd0;
          end else begin
            num = num_nx; dig = dig_nx;
          end
        end else begin
          dec_v[dec_n] = st_i.num[7:0]; dec_n = dec_n + 2'd1;
          num = 10'd0; dig = 2'd0; do_plain = 1'b1;
        end
      end
      MODE_ZX: begin
        if (hx[4]) begin
          mode = MODE_HEX;
          num  = {6'd0, hx[3:0]};
          dig  = 2'd1;
        end else begin
          dec_v[dec_n] = 8'd0; dec_n = dec_n + 2'd1;
          dec_v[dec_n] = st_i.num[7:0]; dec_n = dec_n + 2'd1;
          num = 10'd0; dig = 2'd0; do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    // character decoded as plain text
    if (do_plain) begin
      mode = MODE_PLAIN;
      if (char_i == CH_BACKSLASH) begin
        mode = MODE_ESC;
      end else begin
        dec_v[dec_n] = char_i; dec_n = dec_n + 2'd1;
      end
    end

    // close whatever is open at the end of the literal
    if (final_i) begin
      case (mode)
        MODE_ESC: begin
          dec_v[dec_n] = 8'd0; dec_n = dec_n + 2'd1;
        end
        MODE_OCT, MODE_DEC, MODE_HEX: begin
          dec_v[dec_n] = num[7:0]; dec_n = dec_n + 2'd1;
        end
        MODE_ZX: begin
          dec_v[dec_n] = 8'd0; dec_n = dec_n + 2'd1;
          dec_v[dec_n] = num[7:0]; dec_n = dec_n + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // held byte goes in front of the new bytes
  always_comb begin
    if (st_i.held_valid) begin
      lst[0] = st_i.held_byte;
      lst[1] = dec_v[0];
      lst[2] = dec_v[1];
      lst[3] = dec_v[2];
    end else begin
      lst[0] = dec_v[0];
      lst[1] = dec_v[1];
      lst[2] = dec_v[2];
      lst[3] = 8'd0;
    end
    n    = {2'd0, st_i.held_valid} + {1'b0, dec_n};
    m    = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
    last = 2'(n - 3'd1);
  end

  always_comb begin
    st_o.mode       = mode;
    st_o.num        = num;
    st_o.digits     = dig;
    st_o.held_byte  = st_i.held_byte;
    st_o.held_valid = st_i.held_valid;
    res_cnt_o       = m;
    for (int i = 0; i < MaxRes; i++) begin
      res_o[i].data     = lst[i];
      res_o[i].end_mark = final_i && (2'(i) == m - 2'd1);
      res_o[i].no_data  = 1'b0;
    end
    if (!final_i) begin
      if (n != 3'd0) begin
        st_o.held_byte  = lst[last];
        st_o.held_valid = 1'b1;
      end
    end else begin
      st_o.mode       = MODE_PLAIN;
      st_o.num        = 10'd0;
      st_o.digits     = 2'd0;
      st_o.held_byte  = 8'd0;
      st_o.held_valid = 1'b0;
      if (m == 2'd0) begin
        // empty string: one flagged result
        res_cnt_o         = 2'd1;
        res_o[0].data     = 8'd0;
        res_o[0].end_mark = 1'b1;
        res_o[0].no_data  = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/c_string_escape_decoder.sv -----
// results of a taken character enter the result queue; the last decoded byte is held back
// throughput: one character per cycle while each character yields at most one result
// and out_ready_i is high; two or three results drop in_ready_o until the four-entry queue,
// draining one result per cycle while out_ready_i is high, holds one entry or none again
// reset: async active low, decoder back to plain mode, hold and result queue empty
module c_string_escape_decoder import csed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       final_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       end_mark_o,
  output logic       no_data_o
);

  localparam int unsigned QDepth = 4;

  // decoder state (mode, number in progress, one-byte hold)
  st_t        st_q;
  st_t        st_d;

  // results of the current request
  res_t       res [MaxRes];
  logic [1:0] res_cnt;

  // result queue: small ring of registers, read at the head only
  res_t       q_mem [QDepth];
  logic [1:0] rd_ptr_q;
  logic [1:0] wr_ptr_q;
  logic [2:0] cnt_q;
  logic [2:0] cnt_d;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] push_n;

  csed_decode u_decode (
    .st_i      (st_q),
    .char_i    (in_char_i),
    .final_i   (final_char_i),
    .st_o      (st_d),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  // take a request only when the queue has room for the worst case of three results
  assign in_ready_o  = (cnt_q <= 3'd1);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign push_n      = in_acc ? res_cnt : 2'd0;
  assign cnt_d       = cnt_q + {1'b0, push_n} - {2'd0, out_acc};

  assign out_byte_o  = q_mem[rd_ptr_q].data;
  assign end_mark_o  = q_mem[rd_ptr_q].end_mark;
  assign no_data_o   = q_mem[rd_ptr_q].no_data;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= '{mode: MODE_PLAIN, num: 10'd0, digits: 2'd0,
                    held_byte: 8'd0, held_valid: 1'b0};
      rd_ptr_q <= 2'd0;
      wr_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      if (in_acc) begin
        st_q <= st_d;
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      wr_ptr_q <= wr_ptr_q + push_n;
      cnt_q    <= cnt_d;
    end
  end

  // queue payload, written at up to three consecutive slots
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (2'(i) < push_n) begin
        q_mem[wr_ptr_q + 2'(i)] <= res[i];
      end
    end
  end

  // queue never exceeds its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(QDepth))
    else $error("result queue overflow");

  // fill count agrees with the pointers
  a_cnt_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[1:0] == 2'(wr_ptr_q - rd_ptr_q))
    else $error("queue count and pointers disagree");

  // empty-string result is always the last of its string
  a_no_data_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_data_o |-> end_mark_o)
    else $error("empty flag without end mark");

  // the final character leaves the decoder in its reset state
  a_final_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && final_char_i |=> !st_q.held_valid && st_q.mode == MODE_PLAIN)
    else $error("decoder state not cleared after final character");

  // every accepted final character releases at least its end result
  a_final_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && final_char_i |-> res_cnt != 2'd0)
    else $error("final character gave no result");

endmodule

// ----- tb/csed_checker.sv -----
module csed_checker import csed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_char_i,
  input  logic       final_char_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       end_mark_i,
  input  logic       no_data_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  // decoder state as the predictor sees it
  mode_e      scan_mode;
  logic [9:0] number_value;
  logic [1:0] digit_count;
  logic [7:0] held_byte;
  logic       held_valid;

  res_t pending_results[$];

  // decode one character and queue the results it releases
  task automatic decode_char(input logic [7:0] c, input logic fin);
    logic [7:0] made[$];
    logic [7:0] seq[$];
    logic       reparse;
    int         hx;
    int         m;
    res_t       r;
    reparse = 1'b0;
    hx = -1;
    if (c >= CH_ZERO && c <= CH_NINE) hx = c - CH_ZERO;
    else if (c >= CH_LOWER_A && c <= CH_LOWER_F) hx = c - CH_LOWER_A + 10;
    else if (c >= CH_UPPER_A && c <= CH_UPPER_F) hx = c - CH_UPPER_A + 10;

    case (scan_mode)
      MODE_ESC: begin
        scan_mode = MODE_PLAIN;
        number_value = '0;
        digit_count = '0;
        if (c == CH_LOWER_T) made.push_back(CH_TAB);
        else if (c == CH_LOWER_R) made.push_back(CH_CR);
        else if (c == CH_LOWER_N) made.push_back(CH_LF);
        else if (c == CH_LOWER_A) made.push_back(CH_BELL);
        else if (c == CH_ZERO) scan_mode = MODE_OCT;
        else if (c >= CH_ONE && c <= CH_NINE) begin
          scan_mode = MODE_DEC;
          number_value = 10'(c - CH_ZERO);
          digit_count = 2'd1;
        end else if (c == CH_LOWER_X) scan_mode = MODE_HEX;
        else made.push_back(c);
      end
      MODE_OCT: begin
        if (c >= CH_ZERO && c <= CH_SEVEN) begin
          number_value = number_value * 10'd8 + 10'(c - CH_ZERO);
          digit_count = digit_count + 2'd1;
          if (digit_count == 2'd3) begin
            made.push_back(number_value[7:0]);
            number_value = '0;
            digit_count = '0;
            scan_mode = MODE_PLAIN;
          end
        end else if (digit_count == 2'd0 && (c == CH_LOWER_X || c == CH_UPPER_X)) begin
          scan_mode = MODE_ZX;
          number_value = {2'b00, c};
        end else begin
          made.push_back(number_value[7:0]);
          number_value = '0;
          digit_count = '0;
          reparse = 1'b1;
        end
      end
      MODE_DEC: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          number_value = number_value * 10'd10 + 10'(c - CH_ZERO);
          digit_count = digit_count + 2'd1;
          if (digit_count == 2'd3) begin
            made.push_back(number_value[7:0]);
            number_value = '0;
            digit_count = '0;
            scan_mode = MODE_PLAIN;
          end
        end else begin
          made.push_back(number_value[7:0]);
          number_value = '0;
          digit_count = '0;
          reparse = 1'b1;
        end
      end
      MODE_HEX: begin
        if (hx >= 0) begin
          number_value = number_value * 10'd16 + 10'(hx);
          digit_count = digit_count + 2'd1;
          if (digit_count >= 2'd2) begin
            made.push_back(number_value[7:0]);
            number_value = '0;
            digit_count = '0;
            scan_mode = MODE_PLAIN;
          end
        end else begin
          made.push_back(number_value[7:0]);
          number_value = '0;
          digit_count = '0;
          reparse = 1'b1;
        end
      end
      MODE_ZX: begin
        if (hx >= 0) begin
          scan_mode = MODE_HEX;
          number_value = 10'(hx);
          digit_count = 2'd1;
        end else begin
          // zero byte, then the x letter as written
          made.push_back(8'h00);
          made.push_back(number_value[7:0]);
          number_value = '0;
          digit_count = '0;
          reparse = 1'b1;
        end
      end
      default: reparse = 1'b1;
    endcase

    if (reparse) begin
      if (c == CH_BACKSLASH) scan_mode = MODE_ESC;
      else begin
        scan_mode = MODE_PLAIN;
        made.push_back(c);
      end
    end

    // literal ends inside an escape
    if (fin) begin
      case (scan_mode)
        MODE_ESC: made.push_back(8'h00);
        MODE_OCT, MODE_DEC, MODE_HEX: made.push_back(number_value[7:0]);
        MODE_ZX: begin
          made.push_back(8'h00);
          made.push_back(number_value[7:0]);
        end
        default: ;
      endcase
    end

    if (held_valid) seq.push_back(held_byte);
    foreach (made[i]) seq.push_back(made[i]);

    if (!fin) begin
      if (seq.size() > 0) begin
        m = seq.size() - 1;
        if (m > MaxRes) m = MaxRes;
        for (int i = 0; i < m; i++) begin
          r.data = seq[i];
          r.end_mark = 1'b0;
          r.no_data = 1'b0;
          pending_results.push_back(r);
        end
        held_byte = seq[seq.size() - 1];
        held_valid = 1'b1;
      end
    end else begin
      // last decoded byte, normally the closing quote, is dropped
      m = (seq.size() > 0) ? seq.size() - 1 : 0;
      if (m > MaxRes) m = MaxRes;
      scan_mode = MODE_PLAIN;
      number_value = '0;
      digit_count = '0;
      held_byte = '0;
      held_valid = 1'b0;
      if (m == 0) begin
        r.data = 8'h00;
        r.end_mark = 1'b1;
        r.no_data = 1'b1;
        pending_results.push_back(r);
      end else begin
        for (int i = 0; i < m; i++) begin
          r.data = seq[i];
          r.end_mark = (i + 1 == m);
          r.no_data = 1'b0;
          pending_results.push_back(r);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      scan_mode = MODE_PLAIN;
      number_value = '0;
      digit_count = '0;
      held_byte = '0;
      held_valid = 1'b0;
      pending_results.delete();
      fail_count_o = 0;
      checked_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: byte %02h end %b empty %b", $time,
                   out_byte_i, end_mark_i, no_data_i);
          fail_count_o++;
        end else begin
          want = pending_results.pop_front();
          checked_o++;
          if (out_byte_i !== want.data) begin
            $display("%0t out_byte mismatch: expected %02h, got %02h", $time,
                     want.data, out_byte_i);
            fail_count_o++;
          end
          if (end_mark_i !== want.end_mark) begin
            $display("%0t end_mark mismatch: expected %b, got %b", $time,
                     want.end_mark, end_mark_i);
            fail_count_o++;
          end
          if (no_data_i !== want.no_data) begin
            $display("%0t no_data mismatch: expected %b, got %b", $time,
                     want.no_data, no_data_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_char(in_char_i, final_char_i);
      pending_o = pending_results.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  import csed_pkg::*;

  // characters the stimulus needs beyond the package set
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // rough character budget for the whole run
  localparam int DirectedChars = 25;
  localparam int PhaseChars    = 112;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] in_char_i = 8'h00;
  logic       final_char_i = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       end_mark_o;
  logic       no_data_o;

  int fail_count;
  int pending;
  int checked;

  // percentages of cycles the sender idles and the receiver stalls
  int idle_pct = 0;
  int stall_pct = 0;

  int n_chars = 0;
  int n_strings = 0;

  c_string_escape_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_char_i   (in_char_i),
    .final_char_i(final_char_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .end_mark_o  (end_mark_o),
    .no_data_o   (no_data_o)
  );

  // watches both channels, predicts every result and compares
  csed_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_char_i   (in_char_i),
    .final_char_i(final_char_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_i  (out_byte_o),
    .end_mark_i  (end_mark_o),
    .no_data_i   (no_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // receiver side: random backpressure at the current stall rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // one character request; valid holds until the request is taken
  task automatic send_char(input logic [7:0] c, input logic fin);
    logic rdy;
    // random gap with valid low before the request
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_char_i <= c;
    final_char_i <= fin;
    // ready sampled mid-cycle, the request is taken at the next rising edge
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    n_chars++;
  endtask

  // whole literal, final flag on its last character
  task automatic send_literal(input logic [7:0] txt[$]);
    foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
    n_strings++;
  endtask

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(v - 10);
  endfunction

  // random literal built mostly from well-formed escapes with random content
  task automatic send_random_literal();
    logic [7:0] txt[$];
    int ntok;
    int kind;
    ntok = $urandom_range(0, 6);
    for (int t = 0; t < ntok; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) txt.push_back(8'($urandom_range(8'h20, 8'h7E)));
      else if (kind < 30) txt.push_back(8'($urandom_range(0, 255)));
      else if (kind < 42) begin
        // named control escapes
        txt.push_back(CH_BACKSLASH);
        case ($urandom_range(0, 3))
          0: txt.push_back(CH_LOWER_T);
          1: txt.push_back(CH_LOWER_R);
          2: txt.push_back(CH_LOWER_N);
          default: txt.push_back(CH_LOWER_A);
        endcase
      end else if (kind < 52) begin
        // octal after a leading zero
        txt.push_back(CH_BACKSLASH);
        txt.push_back(CH_ZERO);
        repeat ($urandom_range(0, 3)) txt.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
      end else if (kind < 64) begin
        // decimal, up to three digits, large values wrap
        txt.push_back(CH_BACKSLASH);
        txt.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
        repeat ($urandom_range(0, 2)) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end else if (kind < 76) begin
        txt.push_back(CH_BACKSLASH);
        txt.push_back(CH_LOWER_X);
        repeat ($urandom_range(0, 2)) txt.push_back(hex_char());
      end else if (kind < 86) begin
        // zero then x or X, hex digits optional
        txt.push_back(CH_BACKSLASH);
        txt.push_back(CH_ZERO);
        txt.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
        repeat ($urandom_range(0, 2)) txt.push_back(hex_char());
      end else if (kind < 92) begin
        // sign or space right after backslash-x
        txt.push_back(CH_BACKSLASH);
        txt.push_back(CH_LOWER_X);
        case ($urandom_range(0, 2))
          0: txt.push_back(CH_PLUS);
          1: txt.push_back(CH_MINUS);
          default: txt.push_back(CH_SPACE);
        endcase
        txt.push_back(hex_char());
      end else begin
        // any escaped byte; one that starts no named or numeric escape passes through
        txt.push_back(CH_BACKSLASH);
        txt.push_back(8'($urandom_range(0, 255)));
      end
    end
    // mostly closed by a quote, sometimes the literal stops mid-escape
    if (txt.size() == 0 || $urandom_range(0, 99) < 85) txt.push_back(CH_QUOTE);
    send_literal(txt);
  endtask

  initial begin
    logic [7:0] txt[$];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed literals, no idling
    txt = '{CH_QUOTE};
    send_literal(txt);
    txt = '{8'h00, 8'hFF, CH_QUOTE};
    send_literal(txt);
    txt = '{CH_BACKSLASH, CH_LOWER_T, CH_BACKSLASH, CH_LOWER_R, CH_BACKSLASH, CH_LOWER_N,
            CH_BACKSLASH, CH_LOWER_A, CH_QUOTE};
    send_literal(txt);
    // zero-x with no hex digit
    txt = '{CH_BACKSLASH, CH_ZERO, CH_LOWER_X, CH_QUOTE};
    send_literal(txt);
    // backslash-x with a sign, then a lone trailing backslash
    txt = '{CH_BACKSLASH, CH_LOWER_X, CH_PLUS, CH_BACKSLASH};
    send_literal(txt);
    // decimal cut short by another character
    txt = '{CH_BACKSLASH, CH_NINE, CH_NINE, CH_LOWER_X};
    send_literal(txt);
    // literal ending inside an octal number
    txt = '{CH_LOWER_A, CH_BACKSLASH, CH_ZERO, CH_SEVEN};
    send_literal(txt);

    // random literals over the idle and stall phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      while (n_chars < DirectedChars + (ph + 1) * PhaseChars) send_random_literal();
    end
    in_valid_i <= 1'b0;

    // drain what is still owed, then let the pipeline settle
    // the checker sees the last request at this rising edge, so look at the falling edge
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d characters in %0d literals, %0d decoded results compared",
             n_chars, n_strings, checked);
    $display("phases: no idling, sender idle, receiver stalling, both lightly");
    if (fail_count == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
